### src/assert_macros.svh
// assertion helpers used by the rtl
// ASSERT_CLKRST checks a property on every rising edge outside reset
// ASSERT_CLK checks a property on every rising edge, reset or not
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_CLKRST(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed: lbl");

`define ASSERT_CLK(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed: lbl");

`else

`define ASSERT_CLKRST(lbl, clk, rst_n, prop)

`define ASSERT_CLK(lbl, clk, prop)

`endif

`endif

### src/ccc_pkg.sv
`timescale 1ns / 1ps

package ccc_pkg;

    localparam int OP_W       = 5;
    localparam int CC_W       = 2;
    localparam int WORD_W     = 64;
    localparam int IN_DATA_W  = 3 * WORD_W;
    localparam int OUT_DATA_W = 8;

    typedef logic [OP_W-1:0]       t_op;
    typedef logic [CC_W-1:0]       t_cc;
    typedef logic [IN_DATA_W-1:0]  t_in_data;
    typedef logic [OUT_DATA_W-1:0] t_out_data;

    // operation codes
    localparam t_op OP_CC0     = 5'd0;
    localparam t_op OP_CC1     = 5'd1;
    localparam t_op OP_CC2     = 5'd2;
    localparam t_op OP_CC3     = 5'd3;
    localparam t_op OP_SCMP32  = 5'd4;
    localparam t_op OP_SCMP64  = 5'd5;
    localparam t_op OP_UCMP32  = 5'd6;
    localparam t_op OP_UCMP64  = 5'd7;
    localparam t_op OP_LTGT32  = 5'd8;
    localparam t_op OP_LTGT64  = 5'd9;
    localparam t_op OP_TM32    = 5'd10;
    localparam t_op OP_TM64    = 5'd11;
    localparam t_op OP_NZ      = 5'd12;
    localparam t_op OP_ADD32   = 5'd13;
    localparam t_op OP_ADD64   = 5'd14;
    localparam t_op OP_SUB32   = 5'd15;
    localparam t_op OP_SUB64   = 5'd16;
    localparam t_op OP_ADDU32  = 5'd17;
    localparam t_op OP_ADDU64  = 5'd18;
    localparam t_op OP_SUBU32  = 5'd19;
    localparam t_op OP_SUBU64  = 5'd20;
    localparam t_op OP_ABS32   = 5'd21;
    localparam t_op OP_ABS64   = 5'd22;
    localparam t_op OP_NABS32  = 5'd23;
    localparam t_op OP_NABS64  = 5'd24;
    localparam t_op OP_COMP32  = 5'd25;
    localparam t_op OP_COMP64  = 5'd26;
    localparam t_op OP_ICM     = 5'd27;
    localparam t_op OP_SLA     = 5'd28;

    // condition code values
    localparam t_cc CC_0 = 2'd0;
    localparam t_cc CC_1 = 2'd1;
    localparam t_cc CC_2 = 2'd2;
    localparam t_cc CC_3 = 2'd3;

    // raw operand facts, both widths
    typedef struct packed {
        t_op  op;
        logic a_z32,  a_z64,  a_n32,  a_n64;
        logic b_z32,  b_z64,  b_n32,  b_n64;
        logic r_z32,  r_z64,  r_n32,  r_n64;
        logic eq32,   eq64;
        logic slt32,  slt64,  ult32,  ult64;
        logic rla32,  rla64,  rlb32,  rlb64;
        logic bmin32, bmin64;
        logic tm_none, tm_all, tm_bit;
        logic icm_full, icm_none, icm_top;
        logic sla_ovf;
    } t_flags;

    // facts reduced to the width the operation uses
    typedef struct packed {
        t_op  op;
        logic a_z, a_n;
        logic b_z, b_n;
        logic r_z, r_n;
        logic eq, slt, ult;
        logic rla, rlb;
        logic bmin;
        logic tm_none, tm_all, tm_bit;
        logic icm_full, icm_none, icm_top;
        logic sla_ovf;
    } t_sel;

    // 0 zero, 1 negative, 2 positive
    function automatic t_cc sign_code(input logic is_zero, input logic is_neg);
        t_cc cc;
        if (is_zero) begin
            cc = CC_0;
        end else if (is_neg) begin
            cc = CC_1;
        end else begin
            cc = CC_2;
        end
        return cc;
    endfunction

    // 0 equal, 1 first low, 2 first high
    function automatic t_cc cmp_code(input logic is_eq, input logic is_lt);
        t_cc cc;
        if (is_eq) begin
            cc = CC_0;
        end else if (is_lt) begin
            cc = CC_1;
        end else begin
            cc = CC_2;
        end
        return cc;
    endfunction

    function automatic logic is_wide_op(input t_op op);
        return (op == OP_SCMP64) || (op == OP_UCMP64) || (op == OP_LTGT64) ||
               (op == OP_NZ)     || (op == OP_ADD64)  || (op == OP_SUB64)  ||
               (op == OP_ADDU64) || (op == OP_SUBU64) || (op == OP_ABS64)  ||
               (op == OP_NABS64) || (op == OP_COMP64) || (op == OP_SLA);
    endfunction

endpackage

### src/condition_code_calculator_unit.sv
`timescale 1ns / 1ps

// condition code calculator: takes an operation code on s_axis_tuser and three
// 64-bit operands on s_axis_tdata, and returns the 2-bit condition code of the
// selected rule on m_axis_tdata, with m_axis_tuser set for operation codes 29-31
// (condition code 0 then). 32-bit rules look at the low word of each operand only.
// the unit is a three-stage pipeline: stage 1 does the wide compares and zero
// tests, stage 2 narrows them to the width the operation uses, stage 3 applies
// the rule and is the output register. an accepted transaction moves through
// the stage 1, 2 and 3 registers in turn; a new one is taken every cycle while
// s_axis_tready is high. each stage holds when the stage after it is full and
// stalled, so backpressure on m_axis_tready reaches s_axis_tready only once all
// three stages are occupied; a bubble is filled even while the output is stalled.
module condition_code_calculator_unit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input transactions
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [63:0] first_operand, [127:64] second_operand, [191:128] result_value
    input  ccc_pkg::t_in_data     s_axis_tdata,
    // [4:0] operation
    input  ccc_pkg::t_op          s_axis_tuser,
    // result transactions
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [1:0] cond_code, [7:2] zero
    output ccc_pkg::t_out_data    m_axis_tdata,
    // [0] bad_operation
    output logic                  m_axis_tuser
);

    import ccc_pkg::*;

    `include "assert_macros.svh"

    // stage enables: a stage loads when it is empty or the next one loads
    logic en1, en2, en3;

    logic   r_v1, r_v2, r_v3;
    t_flags r_f1, n_f1;
    t_sel   r_s2, n_s2;
    t_cc    r_cc3, n_cc3;
    logic   r_bad3, n_bad3;

    // operand views
    logic [WORD_W-1:0] op_a, op_b, op_r;
    logic [WORD_W-1:0] sla_x, sla_top;
    logic [15:0]       tm_and;
    logic              tm_sel;
    logic              wide;
    logic              pos_a, pos_b, add_ovf, sub_ovf;

    assign en3 = !r_v3 || m_axis_tready;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;

    assign s_axis_tready = en1;

    assign op_a = s_axis_tdata[WORD_W-1:0];
    assign op_b = s_axis_tdata[2*WORD_W-1:WORD_W];
    assign op_r = s_axis_tdata[3*WORD_W-1:2*WORD_W];

    // stage 1: compares, zero tests and the mask based searches
    always_comb begin
        // test under mask looks at the leftmost selected bit of the low halfword
        tm_and = op_a[15:0] & op_b[15:0];
        tm_sel = op_a[0];
        for (int i = 1; i < 16; i++) begin
            if (op_b[i]) begin
                tm_sel = op_a[i];
            end
        end

        // shift overflow: any of the top count+1 bits differs from the sign
        sla_x   = op_a ^ {WORD_W{op_a[WORD_W-1]}};
        sla_top = {WORD_W{1'b1}} << (6'd63 - op_b[5:0]);

        n_f1.op     = s_axis_tuser;
        n_f1.a_z32  = (op_a[31:0] == 32'd0);
        n_f1.a_z64  = (op_a == 64'd0);
        n_f1.a_n32  = op_a[31];
        n_f1.a_n64  = op_a[63];
        n_f1.b_z32  = (op_b[31:0] == 32'd0);
        n_f1.b_z64  = (op_b == 64'd0);
        n_f1.b_n32  = op_b[31];
        n_f1.b_n64  = op_b[63];
        n_f1.r_z32  = (op_r[31:0] == 32'd0);
        n_f1.r_z64  = (op_r == 64'd0);
        n_f1.r_n32  = op_r[31];
        n_f1.r_n64  = op_r[63];
        n_f1.eq32   = (op_a[31:0] == op_b[31:0]);
        n_f1.eq64   = (op_a == op_b);
        n_f1.slt32  = ($signed(op_a[31:0]) < $signed(op_b[31:0]));
        n_f1.slt64  = ($signed(op_a) < $signed(op_b));
        n_f1.ult32  = (op_a[31:0] < op_b[31:0]);
        n_f1.ult64  = (op_a < op_b);
        n_f1.rla32  = (op_r[31:0] < op_a[31:0]);
        n_f1.rla64  = (op_r < op_a);
        n_f1.rlb32  = (op_r[31:0] < op_b[31:0]);
        n_f1.rlb64  = (op_r < op_b);
        n_f1.bmin32 = (op_b[31:0] == 32'h8000_0000);
        n_f1.bmin64 = (op_b == 64'h8000_0000_0000_0000);

        // the whole 32-bit mask is compared against the 16-bit product
        n_f1.tm_none = (tm_and == 16'd0) || (op_b[31:0] == 32'd0);
        n_f1.tm_all  = ({16'd0, tm_and} == op_b[31:0]);
        n_f1.tm_bit  = tm_sel;

        // insert under mask: the highest mask bit picks the byte sign tested
        n_f1.icm_full = (op_a[31:0] == 32'h0000_000f);
        n_f1.icm_none = (op_a[31:0] == 32'd0) || (op_b[31:0] == 32'd0);
        if (op_a[31:4] != 28'd0) begin
            n_f1.icm_top = 1'b0;
        end else if (op_a[3]) begin
            n_f1.icm_top = op_b[31];
        end else if (op_a[2]) begin
            n_f1.icm_top = op_b[23];
        end else if (op_a[1]) begin
            n_f1.icm_top = op_b[15];
        end else begin
            n_f1.icm_top = op_b[7];
        end

        n_f1.sla_ovf = ((sla_x & sla_top) != 64'd0);
    end

    // stage 2: pick the 32 or 64 bit view for the operation
    always_comb begin
        wide = is_wide_op(r_f1.op);

        n_s2.op       = r_f1.op;
        n_s2.a_z      = wide ? r_f1.a_z64  : r_f1.a_z32;
        n_s2.a_n      = wide ? r_f1.a_n64  : r_f1.a_n32;
        n_s2.b_z      = wide ? r_f1.b_z64  : r_f1.b_z32;
        n_s2.b_n      = wide ? r_f1.b_n64  : r_f1.b_n32;
        n_s2.r_z      = wide ? r_f1.r_z64  : r_f1.r_z32;
        n_s2.r_n      = wide ? r_f1.r_n64  : r_f1.r_n32;
        n_s2.eq       = wide ? r_f1.eq64   : r_f1.eq32;
        n_s2.slt      = wide ? r_f1.slt64  : r_f1.slt32;
        n_s2.ult      = wide ? r_f1.ult64  : r_f1.ult32;
        n_s2.rla      = wide ? r_f1.rla64  : r_f1.rla32;
        n_s2.rlb      = wide ? r_f1.rlb64  : r_f1.rlb32;
        n_s2.bmin     = wide ? r_f1.bmin64 : r_f1.bmin32;
        n_s2.tm_none  = r_f1.tm_none;
        n_s2.tm_all   = r_f1.tm_all;
        n_s2.tm_bit   = r_f1.tm_bit;
        n_s2.icm_full = r_f1.icm_full;
        n_s2.icm_none = r_f1.icm_none;
        n_s2.icm_top  = r_f1.icm_top;
        n_s2.sla_ovf  = r_f1.sla_ovf;
    end

    // stage 3: apply the rule
    always_comb begin
        pos_a = !r_s2.a_n && !r_s2.a_z;
        pos_b = !r_s2.b_n && !r_s2.b_z;
        // signed overflow; the subtract form treats a zero first operand as positive
        add_ovf = (pos_a && pos_b && r_s2.r_n) || (r_s2.a_n && r_s2.b_n && !r_s2.r_n);
        sub_ovf = (!r_s2.a_n && r_s2.b_n && r_s2.r_n) || (r_s2.a_n && pos_b && !r_s2.r_n);

        n_bad3 = 1'b0;
        unique case (r_s2.op)
            OP_CC0, OP_CC1, OP_CC2, OP_CC3: begin
                n_cc3 = r_s2.op[CC_W-1:0];
            end
            OP_SCMP32, OP_SCMP64: begin
                n_cc3 = cmp_code(r_s2.eq, r_s2.slt);
            end
            OP_UCMP32, OP_UCMP64: begin
                n_cc3 = cmp_code(r_s2.eq, r_s2.ult);
            end
            OP_LTGT32, OP_LTGT64: begin
                n_cc3 = sign_code(r_s2.b_z, r_s2.b_n);
            end
            OP_TM32: begin
                n_cc3 = r_s2.tm_none ? CC_0 : (r_s2.tm_all ? CC_3 : CC_1);
            end
            OP_TM64: begin
                if (r_s2.tm_none) begin
                    n_cc3 = CC_0;
                end else if (r_s2.tm_all) begin
                    n_cc3 = CC_3;
                end else begin
                    n_cc3 = r_s2.tm_bit ? CC_2 : CC_1;
                end
            end
            OP_NZ, OP_NABS32, OP_NABS64: begin
                n_cc3 = r_s2.b_z ? CC_0 : CC_1;
            end
            OP_ADD32, OP_ADD64: begin
                n_cc3 = add_ovf ? CC_3 : sign_code(r_s2.r_z, r_s2.r_n);
            end
            OP_SUB32, OP_SUB64: begin
                n_cc3 = sub_ovf ? CC_3 : sign_code(r_s2.r_z, r_s2.r_n);
            end
            OP_ADDU32, OP_ADDU64: begin
                // carry shows as a result below either operand
                if (r_s2.r_z) begin
                    n_cc3 = r_s2.a_z ? CC_0 : CC_2;
                end else begin
                    n_cc3 = (r_s2.rla || r_s2.rlb) ? CC_3 : CC_1;
                end
            end
            OP_SUBU32, OP_SUBU64: begin
                if (r_s2.r_z) begin
                    n_cc3 = CC_2;
                end else begin
                    n_cc3 = r_s2.ult ? CC_1 : CC_3;
                end
            end
            OP_ABS32, OP_ABS64: begin
                if (r_s2.bmin) begin
                    n_cc3 = CC_3;
                end else begin
                    n_cc3 = r_s2.b_z ? CC_0 : CC_2;
                end
            end
            OP_COMP32, OP_COMP64: begin
                n_cc3 = r_s2.bmin ? CC_3 : sign_code(r_s2.b_z, r_s2.b_n);
            end
            OP_ICM: begin
                if (r_s2.icm_full) begin
                    n_cc3 = sign_code(r_s2.b_z, r_s2.b_n);
                end else if (r_s2.icm_none) begin
                    n_cc3 = CC_0;
                end else begin
                    n_cc3 = r_s2.icm_top ? CC_1 : CC_2;
                end
            end
            OP_SLA: begin
                // without overflow the shifted result keeps the sign of the source
                n_cc3 = r_s2.sla_ovf ? CC_3 : sign_code(r_s2.a_z, r_s2.a_n);
            end
            default: begin
                n_cc3  = CC_0;
                n_bad3 = 1'b1;
            end
        endcase
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= s_axis_tvalid;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (en1 && s_axis_tvalid) begin
            r_f1 <= n_f1;
        end
        if (en2 && r_v1) begin
            r_s2 <= n_s2;
        end
        if (en3 && r_v2) begin
            r_cc3  <= n_cc3;
            r_bad3 <= n_bad3;
        end
    end

    assign m_axis_tvalid = r_v3;
    assign m_axis_tdata  = {{(OUT_DATA_W-CC_W){1'b0}}, r_cc3};
    assign m_axis_tuser  = r_bad3;

    // an accepted transaction always lands in stage 1
    `ASSERT_CLKRST(a_accept_enters, i_clk, i_rst_n,
        (s_axis_tvalid && s_axis_tready) |=> r_v1)

    // an empty stage 2 never lets a stage 1 item wait
    `ASSERT_CLKRST(a_no_bubble_hold, i_clk, i_rst_n, (r_v1 && !r_v2) |=> r_v2)

    // with the output register empty the input side is open
    `ASSERT_CLKRST(a_ready_when_drained, i_clk, i_rst_n, !r_v3 |-> s_axis_tready)

    // an undefined operation reports condition code zero
    `ASSERT_CLKRST(a_bad_gives_cc0, i_clk, i_rst_n,
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[CC_W-1:0] == CC_0))

endmodule
